FILE: rtl/fidc_pkg.sv
`default_nettype none
package fidc_pkg;

    localparam int unsigned SampleW  = 16;
    localparam int unsigned SpaceW   = 15;
    localparam int unsigned LevelW   = 16;
    localparam int unsigned DutyW    = 23;
    localparam int unsigned StepW    = 18;
    localparam int unsigned DegW     = 17;
    localparam int unsigned OffW     = 18;
    localparam int unsigned ProdW    = 33;
    localparam int unsigned NumW     = 36;
    localparam int unsigned DenW     = 18;
    localparam int unsigned DvdW     = 35;
    localparam int unsigned DvsW     = 19;
    localparam int unsigned QuoW     = 17;
    localparam int unsigned AddrW    = 5;

    localparam logic [DegW-1:0] DegOne = 17'h10000;

    typedef enum logic [2:0] {
        REG_SETPOINT = 3'd0,
        REG_E_SPACE  = 3'd1,
        REG_D_SPACE  = 3'd2,
        REG_L_SMALL  = 3'd3,
        REG_L_MEDIUM = 3'd4,
        REG_L_BIG    = 3'd5,
        REG_L_HUGE   = 3'd6,
        REG_LIMIT    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [SampleW-1:0] setpoint;
        logic [SpaceW-1:0]         error_spacing;
        logic [SpaceW-1:0]         delta_spacing;
        logic [LevelW-1:0]         level_small;
        logic [LevelW-1:0]         level_medium;
        logic [LevelW-1:0]         level_big;
        logic [LevelW-1:0]         level_huge;
        logic [DutyW-1:0]          duty_limit;
    } cfg_t;

    typedef struct packed {
        logic            start;
        logic [DvdW-1:0] dividend;
        logic [DvsW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic            done;
        logic [QuoW-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DELTA,
        S_FZ_INIT,
        S_FZ_K,
        S_FZ_DIV,
        S_RULE,
        S_MUL,
        S_ACC,
        S_QDIV,
        S_DUTY,
        S_OUT
    } state_t;

    function automatic logic signed [SampleW-1:0] sat16(input logic signed [SampleW:0] v);
        logic signed [SampleW-1:0] r;
        if (v > 17'sd32767)
            r = 16'sh7fff;
        else if (v < -17'sd32768)
            r = 16'sh8000;
        else
            r = v[SampleW-1:0];
        return r;
    endfunction

    function automatic logic [SpaceW-1:0] eff_space(input logic [SpaceW-1:0] s);
        return (s == '0) ? SpaceW'(1) : s;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/fidc_if.sv
`default_nettype none
interface fidc_in_if
    import fidc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [SampleW-1:0] sensor_sample;

    modport source (output valid, output sensor_sample, input ready);
    modport sink (input valid, input sensor_sample, output ready);
endinterface

interface fidc_out_if
    import fidc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [DutyW-1:0]        duty_out;
    logic signed [StepW-1:0] step_out;

    modport source (output valid, output duty_out, output step_out, input ready);
    modport sink (input valid, input duty_out, input step_out, output ready);
endinterface
`default_nettype wire

FILE: rtl/fidc_cfg.sv
`default_nettype none
module fidc_cfg
    import fidc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;

    assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setpoint      <= '0;
            cfg_reg.error_spacing <= 15'd512;
            cfg_reg.delta_spacing <= 15'd512;
            cfg_reg.level_small   <= 16'd328;
            cfg_reg.level_medium  <= 16'd655;
            cfg_reg.level_big     <= 16'd1638;
            cfg_reg.level_huge    <= 16'd3277;
            cfg_reg.duty_limit    <= 23'd5570560;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_SETPOINT: cfg_reg.setpoint      <= pwdata[SampleW-1:0];
                REG_E_SPACE:  cfg_reg.error_spacing <= pwdata[SpaceW-1:0];
                REG_D_SPACE:  cfg_reg.delta_spacing <= pwdata[SpaceW-1:0];
                REG_L_SMALL:  cfg_reg.level_small   <= pwdata[LevelW-1:0];
                REG_L_MEDIUM: cfg_reg.level_medium  <= pwdata[LevelW-1:0];
                REG_L_BIG:    cfg_reg.level_big     <= pwdata[LevelW-1:0];
                REG_L_HUGE:   cfg_reg.level_huge    <= pwdata[LevelW-1:0];
                REG_LIMIT:    cfg_reg.duty_limit    <= pwdata[DutyW-1:0];
                default:      cfg_reg.duty_limit    <= cfg_reg.duty_limit;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SETPOINT: prdata = {{(32-SampleW){cfg_reg.setpoint[SampleW-1]}},
                                    cfg_reg.setpoint};
            REG_E_SPACE:  prdata = {{(32-SpaceW){1'b0}}, cfg_reg.error_spacing};
            REG_D_SPACE:  prdata = {{(32-SpaceW){1'b0}}, cfg_reg.delta_spacing};
            REG_L_SMALL:  prdata = {{(32-LevelW){1'b0}}, cfg_reg.level_small};
            REG_L_MEDIUM: prdata = {{(32-LevelW){1'b0}}, cfg_reg.level_medium};
            REG_L_BIG:    prdata = {{(32-LevelW){1'b0}}, cfg_reg.level_big};
            REG_L_HUGE:   prdata = {{(32-LevelW){1'b0}}, cfg_reg.level_huge};
            REG_LIMIT:    prdata = {{(32-DutyW){1'b0}}, cfg_reg.duty_limit};
            default:      prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/fidc_div.sv
`default_nettype none
module fidc_div
    import fidc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  div_req_t  req,
    output div_rsp_t  rsp
);

    // restoring divider, one quotient bit a cycle; quotient known to fit QuoW bits
    logic [DvsW-1:0] rem_reg, rem_next;
    logic [QuoW-1:0] low_reg, low_next;
    logic [QuoW-1:0] quo_reg, quo_next;
    logic [DvsW-1:0] dvs_reg, dvs_next;
    logic [4:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [DvsW:0]   shifted;
    logic [DvsW+1:0] trial;

    assign shifted      = {rem_reg, low_reg[QuoW-1]};
    assign trial        = {1'b0, shifted} - {2'b00, dvs_reg};
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.dividend[DvdW-1:QuoW]};
            low_next  = req.dividend[QuoW-1:0];
            quo_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = 5'(QuoW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[DvsW+1])
                rem_next = trial[DvsW-1:0];
            else
                rem_next = shifted[DvsW-1:0];
            quo_next = {quo_reg[QuoW-2:0], ~trial[DvsW+1]};
            low_next = {low_reg[QuoW-2:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        low_reg <= low_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule
`default_nettype wire

FILE: rtl/fuzzy_incremental_duty_controller_core.sv
// channel     | dir | beat payload
// ------------+-----+--------------------------------------
// sample_ch   | in  | sensor_sample (s16, Q8.8)
// result_ch   | out | duty_out (u23, Q7.16), step_out (s18)
// apb         | in  | eight config registers at 4*i
// a result beat is offered once the work for the accepted sample is done; that work uses
// a bit-serial multiplier (once for each of four rules) and a shared restoring
// divider (up to three uses); saturated operands skip their division
// the next sample is taken once the result sits in the output register
// a stalled result blocks only when the following result is ready to be stored
// reset clears the previous error and the duty, and loads the register defaults
`default_nettype none
module fuzzy_incremental_duty_controller_core
    import fidc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [31:0]      pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    fidc_in_if.sink               sample_ch,
    fidc_out_if.source            result_ch
);

    cfg_t     cfg;
    div_req_t div_req;
    div_rsp_t div_rsp;

    fidc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fidc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    state_t state_reg, state_next;

    logic signed [SampleW-1:0] err_reg, prev_reg, x_reg;
    logic                      phase_reg;
    logic [OffW-1:0]           off_reg;
    logic [2:0]                k_reg, ke_reg, kd_reg;
    logic [DegW-1:0]           ea0_reg, ea1_reg, db0_reg, db1_reg;
    logic [1:0]                rule_reg;
    logic [ProdW-1:0]          mcand_reg, prod_reg;
    logic [LevelW-1:0]         mplier_reg;
    logic [3:0]                mcnt_reg;
    logic                      neg_reg;
    logic signed [NumW-1:0]    num_reg;
    logic [DenW-1:0]           den_reg;
    logic signed [StepW-1:0]   step_reg;
    logic [DutyW-1:0]          duty_reg;
    logic                      ovalid_reg;
    logic [DutyW-1:0]          oduty_reg;
    logic signed [StepW-1:0]   ostep_reg;

    logic [SpaceW-1:0]         sp;
    logic [OffW-1:0]           three_s;
    logic signed [OffW:0]      xs;
    logic                      sat_lo, sat_hi;
    logic [DegW-1:0]           wa, wb, w;
    logic [3:0]                sidx, lidx;
    logic [LevelW-1:0]         mag;
    logic                      lneg;
    logic signed [NumW-1:0]    num_sum;
    logic [NumW-1:0]           num_abs;
    logic signed [DutyW+1:0]   duty_sum;
    logic                      accept;
    logic                      out_free;

    assign accept   = sample_ch.valid && sample_ch.ready;
    assign out_free = !ovalid_reg || result_ch.ready;

    assign sample_ch.ready    = (state_reg == S_IDLE);
    assign result_ch.valid    = ovalid_reg;
    assign result_ch.duty_out = oduty_reg;
    assign result_ch.step_out = ostep_reg;

    // fuzzification of the current operand
    assign sp      = eff_space(phase_reg ? cfg.delta_spacing : cfg.error_spacing);
    assign three_s = {3'b000, sp} + {2'b00, sp, 1'b0};
    assign xs      = {{(OffW+1-SampleW){x_reg[SampleW-1]}}, x_reg};
    assign sat_lo  = xs <= -$signed({1'b0, three_s});
    assign sat_hi  = xs >= $signed({1'b0, three_s});

    // current rule: error slot rule_reg[1], delta slot rule_reg[0]
    assign wa   = rule_reg[1] ? ea1_reg : ea0_reg;
    assign wb   = rule_reg[0] ? db1_reg : db0_reg;
    assign w    = (wa < wb) ? wa : wb;
    assign sidx = {1'b0, ke_reg} + {1'b0, kd_reg} + {3'b000, rule_reg[1]}
                + {3'b000, rule_reg[0]};

    always_comb
    begin
        priority if (sidx <= 4'd2)
            lidx = 4'd0;
        else if (sidx >= 4'd10)
            lidx = 4'd8;
        else
            lidx = sidx - 4'd2;
        lneg = lidx < 4'd4;
        unique case (lidx)
            4'd0, 4'd8: mag = cfg.level_huge;
            4'd1, 4'd7: mag = cfg.level_big;
            4'd2, 4'd6: mag = cfg.level_medium;
            4'd3, 4'd5: mag = cfg.level_small;
            default:    mag = '0;
        endcase
    end

    assign num_sum  = neg_reg ? num_reg - $signed({{(NumW-ProdW){1'b0}}, prod_reg})
                              : num_reg + $signed({{(NumW-ProdW){1'b0}}, prod_reg});
    assign num_abs  = num_sum[NumW-1] ? NumW'(-num_sum) : NumW'(num_sum);
    assign duty_sum = $signed({2'b00, duty_reg})
                    + $signed({{(DutyW+2-StepW){step_reg[StepW-1]}}, step_reg});

    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.dividend = {{(DvdW-SpaceW-16){1'b0}}, off_reg[SpaceW-1:0], 16'h0000};
        div_req.divisor  = {{(DvsW-SpaceW){1'b0}}, sp};
        unique case (state_reg)
            S_IDLE:    if (accept) state_next = S_DELTA;
            S_DELTA:   state_next = S_FZ_INIT;
            S_FZ_INIT:
            begin
                priority if (sat_lo || sat_hi)
                    state_next = phase_reg ? S_RULE : S_FZ_INIT;
                else
                    state_next = S_FZ_K;
            end
            S_FZ_K:
            begin
                if (!(off_reg >= {3'b000, sp} && k_reg < 3'd5))
                begin
                    div_req.start = 1'b1;
                    state_next    = S_FZ_DIV;
                end
            end
            S_FZ_DIV:  if (div_rsp.done) state_next = phase_reg ? S_RULE : S_FZ_INIT;
            S_RULE:    state_next = S_MUL;
            S_MUL:     if (mcnt_reg == 4'd15) state_next = S_ACC;
            S_ACC:
            begin
                if (rule_reg == 2'd3)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = num_abs[DvdW-1:0];
                    div_req.divisor  = {{(DvsW-DenW){1'b0}}, den_reg};
                    state_next       = S_QDIV;
                end
                else
                    state_next = S_RULE;
            end
            S_QDIV:    if (div_rsp.done) state_next = S_DUTY;
            S_DUTY:    state_next = S_OUT;
            S_OUT:     if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prev_reg   <= '0;
            duty_reg   <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DUTY)
                prev_reg <= err_reg;
            if (state_reg == S_DUTY)
            begin
                priority if (duty_sum >= $signed({2'b00, cfg.duty_limit}))
                    duty_reg <= cfg.duty_limit;
                else if (duty_sum <= 0)
                    duty_reg <= '0;
                else
                    duty_reg <= duty_sum[DutyW-1:0];
            end
            if (state_reg == S_OUT && out_free)
                ovalid_reg <= 1'b1;
            else if (ovalid_reg && result_ch.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                err_reg <= sat16($signed({cfg.setpoint[SampleW-1], cfg.setpoint})
                         - $signed({sample_ch.sensor_sample[SampleW-1],
                                    sample_ch.sensor_sample}));
            end
            S_DELTA:
            begin
                x_reg     <= err_reg;
                phase_reg <= 1'b0;
                num_reg   <= '0;
                den_reg   <= '0;
                rule_reg  <= '0;
            end
            S_FZ_INIT:
            begin
                off_reg <= OffW'(xs + $signed({1'b0, three_s}));
                k_reg   <= '0;
                if (sat_lo || sat_hi)
                begin
                    if (phase_reg)
                    begin
                        kd_reg  <= sat_lo ? 3'd0 : 3'd5;
                        db0_reg <= sat_lo ? DegOne : '0;
                        db1_reg <= sat_lo ? '0 : DegOne;
                    end
                    else
                    begin
                        ke_reg  <= sat_lo ? 3'd0 : 3'd5;
                        ea0_reg <= sat_lo ? DegOne : '0;
                        ea1_reg <= sat_lo ? '0 : DegOne;
                        phase_reg <= 1'b1;
                        x_reg     <= sat16($signed({err_reg[SampleW-1], err_reg})
                                   - $signed({prev_reg[SampleW-1], prev_reg}));
                    end
                end
            end
            S_FZ_K:
            begin
                if (off_reg >= {3'b000, sp} && k_reg < 3'd5)
                begin
                    off_reg <= off_reg - {3'b000, sp};
                    k_reg   <= k_reg + 3'd1;
                end
            end
            S_FZ_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (phase_reg)
                    begin
                        kd_reg  <= k_reg;
                        db1_reg <= {1'b0, div_rsp.quotient[15:0]};
                        db0_reg <= DegOne - {1'b0, div_rsp.quotient[15:0]};
                    end
                    else
                    begin
                        ke_reg    <= k_reg;
                        ea1_reg   <= {1'b0, div_rsp.quotient[15:0]};
                        ea0_reg   <= DegOne - {1'b0, div_rsp.quotient[15:0]};
                        phase_reg <= 1'b1;
                        x_reg     <= sat16($signed({err_reg[SampleW-1], err_reg})
                                   - $signed({prev_reg[SampleW-1], prev_reg}));
                    end
                end
            end
            S_RULE:
            begin
                mcand_reg  <= {{(ProdW-DegW){1'b0}}, w};
                mplier_reg <= mag;
                prod_reg   <= '0;
                mcnt_reg   <= '0;
                neg_reg    <= lneg;
                den_reg    <= den_reg + {{(DenW-DegW){1'b0}}, w};
            end
            S_MUL:
            begin
                if (mplier_reg[0])
                    prod_reg <= prod_reg + mcand_reg;
                mcand_reg  <= {mcand_reg[ProdW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[LevelW-1:1]};
                mcnt_reg   <= mcnt_reg + 4'd1;
            end
            S_ACC:
            begin
                num_reg  <= num_sum;
                rule_reg <= rule_reg + 2'd1;
            end
            S_QDIV:
            begin
                if (div_rsp.done)
                begin
                    if (den_reg == '0)
                        step_reg <= '0;
                    else if (num_reg[NumW-1])
                        step_reg <= -$signed({1'b0, div_rsp.quotient});
                    else
                        step_reg <= $signed({1'b0, div_rsp.quotient});
                end
            end
            S_DUTY:
            begin
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    oduty_reg <= duty_reg;
                    ostep_reg <= step_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/fidc_chk.sv
`default_nettype none
module fidc_chk
    import fidc_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    pready,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic signed [StepW-1:0] step_out
);

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while busy");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (step_out <= 18'sd65535) && (step_out >= -18'sd65535))
        else $error("step beyond any singleton");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped");

endmodule

bind fuzzy_incremental_duty_controller_core fidc_chk u_fidc_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .in_valid  (sample_ch.valid),
    .in_ready  (sample_ch.ready),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .step_out  (result_ch.step_out)
);
`default_nettype wire
